>>> rtl/sevq_pkg.sv
// Shared types and constants for the sorted event queue with repeats.
package sevq_pkg;

    // Number of cells in the queue chain
    localparam int QUEUE_DEPTH = 16;
    // Width of the fill count, able to hold QUEUE_DEPTH itself
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // Field widths
    localparam int TICK_W = 32;
    localparam int TYPE_W = 16;
    localparam int WORD_W = 32;
    localparam int OCC_W = 5;

    // One queued event
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [TYPE_W-1:0] etype;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] interval;
        logic [WORD_W-1:0] repeats;
    } entry_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    // Command bus from the sequencer to the cell row
    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_ctrl_t;

    // Operation codes on the input channel
    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_REINS
    } sevq_state_t;

endpackage

>>> rtl/sevq_cell.sv
// One cell of the sorted event chain: holds one event and shifts with its neighbors.
module sevq_cell (
    input  logic                  aclk,
    input  sevq_pkg::cell_ctrl_t  ctrl,
    input  logic                  occupied,
    input  logic                  left_after,
    input  sevq_pkg::entry_t      left_ent,
    input  sevq_pkg::entry_t      right_ent,
    output sevq_pkg::entry_t      ent,
    output logic                  after
);

    sevq_pkg::entry_t ent_reg;
    sevq_pkg::entry_t ent_next;

    // New event sorts after this one (equal tick and type keeps arrival order)
    always_comb begin
        after = occupied &&
                ((ent_reg.tick < ctrl.ent.tick) ||
                 ((ent_reg.tick == ctrl.ent.tick) && (ent_reg.etype <= ctrl.ent.etype)));
    end

    // Next content: keep, take the new event, take the left or the right neighbor
    always_comb begin
        ent_next = ent_reg;
        case (ctrl.op)
            sevq_pkg::CELL_INSERT: begin
                if (after) begin
                    ent_next = ent_reg;
                end else if (left_after) begin
                    ent_next = ctrl.ent;
                end else begin
                    ent_next = left_ent;
                end
            end
            sevq_pkg::CELL_SHIFT: begin
                ent_next = right_ent;
            end
            default: begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

>>> rtl/sorted_event_queue_with_repeats_core.sv
// Top level of the sorted event queue with repeats: sequencer, counters and cell chain.
//
// Usage:
//   Input channel (s_*): one operation per transfer. s_func selects push (the
//   s_event_* fields) or pop-due (compared against s_now_tick).
//   Result channel (m_*): exactly one result per input transfer, in order. It
//   carries ok, the popped event (zeros when nothing is popped), the head after
//   the operation, the occupancy and the running count of successful pops.
// Timing and flow:
//   For a push or a pop without repeat, the result is valid the cycle after
//   the input transfer. A pop whose event repeats first shifts the chain and
//   then, in state ST_REINS, inserts the event again at tick + interval.
//   The block works on one item at a time; a new item is taken in the cycle
//   its predecessor's result is transferred or later.
//   The insert position is found by a compare in every cell at once.
// Reset:
//   aresetn (synchronous, active low) empties the queue, clears the pop count
//   and drops any pending result. Cell contents are not cleared.
// Stall:
//   While m_valid is high and m_ready low, the result and the queue hold and
//   s_ready stays low.
module sorted_event_queue_with_repeats_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_event_tick,
    input  logic [15:0] s_event_type,
    input  logic [31:0] s_event_payload,
    input  logic [31:0] s_event_interval,
    input  logic [31:0] s_event_repeats,
    input  logic [31:0] s_now_tick,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_popped_tick,
    output logic [15:0] m_popped_type,
    output logic [31:0] m_popped_payload,
    output logic [31:0] m_popped_interval,
    output logic [31:0] m_popped_repeats,
    output logic        m_head_valid,
    output logic [31:0] m_head_tick,
    output logic [15:0] m_head_type,
    output logic [31:0] m_head_payload,
    output logic [4:0]  m_occupancy,
    output logic [31:0] m_processed_count
);

    localparam int DEPTH = sevq_pkg::QUEUE_DEPTH;
    localparam int CW    = sevq_pkg::CNT_W;

    // Control state
    sevq_pkg::sevq_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [31:0]           pops_reg, pops_next;
    logic                  m_valid_reg, m_valid_next;

    // Payload registers
    sevq_pkg::entry_t      reins_reg, reins_next;
    sevq_pkg::entry_t      popped_reg, popped_next;
    logic                  ok_reg, ok_next;

    // Cell row
    sevq_pkg::cell_ctrl_t  ctrl;
    sevq_pkg::entry_t      cell_ent [DEPTH];
    logic                  cell_after [DEPTH];
    logic [DEPTH-1:0]      occupied;

    sevq_pkg::entry_t      in_ent;
    sevq_pkg::entry_t      head;
    logic                  accept;
    logic                  full;
    logic                  due;

    assign head   = cell_ent[0];
    assign accept = s_valid && s_ready;
    assign full   = (count_reg == CW'(DEPTH));
    assign due    = (count_reg != '0) && (head.tick <= s_now_tick);

    always_comb begin
        in_ent.tick     = s_event_tick;
        in_ent.etype    = s_event_type;
        in_ent.payload  = s_event_payload;
        in_ent.interval = s_event_interval;
        in_ent.repeats  = s_event_repeats;
    end

    // Which cells hold an event
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occupied[i] = (CW'(i) < count_reg);
        end
    end

    // Sequencer: next state, counters, result and cell command
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pops_next    = pops_reg;
        m_valid_next = m_valid_reg && !m_ready;
        reins_next   = reins_reg;
        popped_next  = popped_reg;
        ok_next      = ok_reg;
        ctrl.op      = sevq_pkg::CELL_HOLD;
        ctrl.ent     = in_ent;
        s_ready      = 1'b0;

        case (state_reg)
            sevq_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (accept) begin
                    popped_next = '0;
                    ok_next     = 1'b0;
                    if (s_func == sevq_pkg::FUNC_PUSH) begin
                        m_valid_next = 1'b1;
                        if (!full) begin
                            ctrl.op    = sevq_pkg::CELL_INSERT;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end else if (due) begin
                        ctrl.op     = sevq_pkg::CELL_SHIFT;
                        count_next  = count_reg - CW'(1);
                        pops_next   = pops_reg + 32'd1;
                        ok_next     = 1'b1;
                        popped_next = head;
                        // Repeating event goes back in at tick + interval
                        reins_next          = head;
                        reins_next.tick     = head.tick + head.interval;
                        reins_next.repeats  = head.repeats - 32'd1;
                        if ((head.interval != '0) && (head.repeats != '0)) begin
                            state_next = sevq_pkg::ST_REINS;
                        end else begin
                            m_valid_next = 1'b1;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            sevq_pkg::ST_REINS: begin
                ctrl.op      = sevq_pkg::CELL_INSERT;
                ctrl.ent     = reins_reg;
                count_next   = count_reg + CW'(1);
                m_valid_next = 1'b1;
                state_next   = sevq_pkg::ST_IDLE;
            end
            default: begin
                state_next = sevq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sevq_pkg::ST_IDLE;
            count_reg   <= '0;
            pops_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pops_reg    <= pops_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        reins_reg  <= reins_next;
        popped_reg <= popped_next;
        ok_reg     <= ok_next;
    end

    // Chain of cells; cell 0 is the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sevq_pkg::entry_t left_ent;
        sevq_pkg::entry_t right_ent;
        logic             left_after;

        if (i == 0) begin : g_first
            assign left_ent   = '0;
            assign left_after = 1'b1;
        end else begin : g_mid
            assign left_ent   = cell_ent[i-1];
            assign left_after = cell_after[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = cell_ent[i+1];
        end

        sevq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occupied[i]),
            .left_after (left_after),
            .left_ent   (left_ent),
            .right_ent  (right_ent),
            .ent        (cell_ent[i]),
            .after      (cell_after[i])
        );
    end

    // Result channel
    assign m_valid           = m_valid_reg;
    assign m_ok              = ok_reg;
    assign m_popped_tick     = popped_reg.tick;
    assign m_popped_type     = popped_reg.etype;
    assign m_popped_payload  = popped_reg.payload;
    assign m_popped_interval = popped_reg.interval;
    assign m_popped_repeats  = popped_reg.repeats;
    assign m_head_valid      = (count_reg != '0);
    assign m_head_tick       = m_head_valid ? head.tick : '0;
    assign m_head_type       = m_head_valid ? head.etype : '0;
    assign m_head_payload    = m_head_valid ? head.payload : '0;
    assign m_occupancy       = sevq_pkg::OCC_W'(count_reg);
    assign m_processed_count = pops_reg;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the sorted event queue with repeating events.
`timescale 1ns / 100ps

module tb_top;
    import sevq_pkg::*;

    localparam int IDLE_PCT   = 18;
    localparam int RAND_ITEMS = 450;
    localparam int STALL_MAX  = 2000;

    // What one result transfer carries
    typedef struct {
        logic              ok;
        entry_t            popped;
        logic              head_valid;
        logic [TICK_W-1:0] head_tick;
        logic [TYPE_W-1:0] head_type;
        logic [WORD_W-1:0] head_payload;
        logic [OCC_W-1:0]  occupancy;
        logic [WORD_W-1:0] processed;
    } outcome_t;

    // Tracks the queued events and the outcomes still owed by the block
    class event_queue_board;
        entry_t   slots[$];
        outcome_t pending_outcomes[$];
        logic [WORD_W-1:0] pops_done;
        int failures, checked;
        int n_push, n_refused, n_pop_hit, n_pop_miss, n_requeued, peak_fill;

        function new();
            pops_done = '0;
            failures = 0;
            checked = 0;
            n_push = 0;
            n_refused = 0;
            n_pop_hit = 0;
            n_pop_miss = 0;
            n_requeued = 0;
            peak_fill = 0;
        endfunction

        // Sorted insert: after all events with the same tick and type
        function void insert_event(entry_t ev);
            int pos;
            pos = 0;
            while (pos < slots.size() && (slots[pos].tick < ev.tick ||
                   (slots[pos].tick == ev.tick && slots[pos].etype <= ev.etype)))
                pos++;
            slots.insert(pos, ev);
        endfunction

        // Apply one accepted operation and queue the outcome it owes
        function void note_request(func_t f, entry_t ev, logic [TICK_W-1:0] now);
            outcome_t res;
            entry_t   head;
            res.ok = 1'b0;
            res.popped = '0;
            if (f == FUNC_PUSH) begin
                n_push++;
                if (slots.size() < QUEUE_DEPTH) begin
                    insert_event(ev);
                    res.ok = 1'b1;
                end else begin
                    n_refused++;
                end
            end else if (slots.size() > 0 && slots[0].tick <= now) begin
                head = slots.pop_front();
                res.ok = 1'b1;
                res.popped = head;
                pops_done = pops_done + 1;
                n_pop_hit++;
                // repeating event goes back at tick + interval, one repeat fewer
                if (head.interval != '0 && head.repeats != '0) begin
                    head.tick = head.tick + head.interval;
                    head.repeats = head.repeats - 1;
                    insert_event(head);
                    n_requeued++;
                end
            end else begin
                n_pop_miss++;
            end
            res.head_valid = (slots.size() > 0);
            res.head_tick = res.head_valid ? slots[0].tick : '0;
            res.head_type = res.head_valid ? slots[0].etype : '0;
            res.head_payload = res.head_valid ? slots[0].payload : '0;
            res.occupancy = OCC_W'(slots.size());
            res.processed = pops_done;
            if (slots.size() > peak_fill)
                peak_fill = slots.size();
            pending_outcomes.push_back(res);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (failures < 10)
                    $display("result %0d: %s mismatch, expected %h, got %h",
                             checked, name, want, got);
                failures++;
            end
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                if (failures < 10)
                    $display("result %0d arrived with nothing outstanding", checked);
                failures++;
            end else begin
                want = pending_outcomes.pop_front();
                match_field("ok", 32'(want.ok), 32'(got.ok));
                match_field("popped_tick", want.popped.tick, got.popped.tick);
                match_field("popped_type", 32'(want.popped.etype), 32'(got.popped.etype));
                match_field("popped_payload", want.popped.payload, got.popped.payload);
                match_field("popped_interval", want.popped.interval, got.popped.interval);
                match_field("popped_repeats", want.popped.repeats, got.popped.repeats);
                match_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                match_field("head_tick", want.head_tick, got.head_tick);
                match_field("head_type", 32'(want.head_type), 32'(got.head_type));
                match_field("head_payload", want.head_payload, got.head_payload);
                match_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                match_field("processed_count", want.processed, got.processed);
            end
            checked++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [31:0] s_event_tick;
    logic [15:0] s_event_type;
    logic [31:0] s_event_payload;
    logic [31:0] s_event_interval;
    logic [31:0] s_event_repeats;
    logic [31:0] s_now_tick;
    logic        m_valid;
    logic        m_ready;
    logic        m_ok;
    logic [31:0] m_popped_tick;
    logic [15:0] m_popped_type;
    logic [31:0] m_popped_payload;
    logic [31:0] m_popped_interval;
    logic [31:0] m_popped_repeats;
    logic        m_head_valid;
    logic [31:0] m_head_tick;
    logic [15:0] m_head_type;
    logic [31:0] m_head_payload;
    logic [4:0]  m_occupancy;
    logic [31:0] m_processed_count;

    event_queue_board board;
    outcome_t seen;
    logic     steady;
    int       stall_cycles;

    sorted_event_queue_with_repeats_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_event_tick      (s_event_tick),
        .s_event_type      (s_event_type),
        .s_event_payload   (s_event_payload),
        .s_event_interval  (s_event_interval),
        .s_event_repeats   (s_event_repeats),
        .s_now_tick        (s_now_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_popped_tick     (m_popped_tick),
        .m_popped_type     (m_popped_type),
        .m_popped_payload  (m_popped_payload),
        .m_popped_interval (m_popped_interval),
        .m_popped_repeats  (m_popped_repeats),
        .m_head_valid      (m_head_valid),
        .m_head_tick       (m_head_tick),
        .m_head_type       (m_head_type),
        .m_head_payload    (m_head_payload),
        .m_occupancy       (m_occupancy),
        .m_processed_count (m_processed_count)
    );

    // Clock, 4 ns period
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Result side backpressure, off during the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.ok = m_ok;
            seen.popped.tick = m_popped_tick;
            seen.popped.etype = m_popped_type;
            seen.popped.payload = m_popped_payload;
            seen.popped.interval = m_popped_interval;
            seen.popped.repeats = m_popped_repeats;
            seen.head_valid = m_head_valid;
            seen.head_tick = m_head_tick;
            seen.head_type = m_head_type;
            seen.head_payload = m_head_payload;
            seen.occupancy = m_occupancy;
            seen.processed = m_processed_count;
            board.check_outcome(seen);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("no transfer for %0d cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One operation on the input channel, with random gaps before it
    task automatic issue(func_t f, entry_t ev, logic [31:0] now);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_event_tick <= ev.tick;
        s_event_type <= ev.etype;
        s_event_payload <= ev.payload;
        s_event_interval <= ev.interval;
        s_event_repeats <= ev.repeats;
        s_now_tick <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_request(f, ev, now);
    endtask

    task automatic push_event(logic [31:0] tk, logic [15:0] ty, logic [31:0] pl,
                              logic [31:0] iv, logic [31:0] rp);
        entry_t ev;
        ev = '{tick: tk, etype: ty, payload: pl, interval: iv, repeats: rp};
        issue(FUNC_PUSH, ev, $urandom);
    endtask

    task automatic pop_due(logic [31:0] now);
        entry_t ev;
        ev = '{tick: $urandom, etype: 16'($urandom), payload: $urandom,
               interval: $urandom, repeats: $urandom};
        issue(FUNC_POP, ev, now);
    endtask

    initial begin
        logic [31:0] cur_now, tk, pl, iv, rp;
        logic [15:0] ty;
        int push_share, roll;

        board = new();
        aresetn = 1'b0;
        steady = 1'b0;
        stall_cycles = 0;
        m_ready = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_PUSH;
        s_event_tick = '0;
        s_event_type = '0;
        s_event_payload = '0;
        s_event_interval = '0;
        s_event_repeats = '0;
        s_now_tick = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pops, field extremes, tick wrap on repeat
        pop_due('0);
        pop_due('1);
        push_event('1, '1, '1, '1, 32'd1);
        pop_due(32'hFFFF_FFFE);                 // head not yet due
        pop_due('1);                            // re-queued at wrapped tick
        pop_due(32'hFFFF_FFFE);                 // last repeat, queue empties
        // repeating head, equal-key ordering, interval without repeats
        push_event('0, '0, '0, 32'd1, 32'd2);
        push_event('0, '0, 32'hA5A5_A5A5, '0, '1);
        push_event('0, '1, 32'h5A5A_5A5A, 32'd3, '0);
        for (int k = 0; k < 13; k++)
            push_event((k % 4) * 5, 16'(k % 3), k, (k % 2) ? 32'd7 : 32'd0, 32'd2);
        push_event(32'd1, 16'd1, 32'd1, 32'd1, 32'd1);   // refused, queue full
        pop_due('0);                            // repeat re-queued into full queue
        pop_due('0);

        // Random: alternating fill and drain phases around a moving current tick
        cur_now = 32'd100;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            steady = (i >= 200 && i < 290);
            push_share = ((i / 50) % 2 == 0) ? 70 : 30;
            if ($urandom_range(99) < push_share) begin
                if ($urandom_range(99) < 88) begin
                    tk = cur_now + $urandom_range(0, 40);
                    ty = 16'($urandom_range(0, 3));
                    pl = $urandom;
                    roll = $urandom_range(99);
                    iv = (roll < 35) ? 32'd0 : (roll < 85) ? $urandom_range(1, 20) : $urandom;
                end else begin
                    tk = $urandom;
                    ty = 16'($urandom);
                    pl = $urandom;
                    iv = $urandom_range(1) ? 32'd0 : $urandom;
                end
                // long repeat counts only on one-shots, so the queue keeps draining
                if (iv == '0 && $urandom_range(1))
                    rp = $urandom;
                else
                    rp = $urandom_range(0, 3);
                push_event(tk, ty, pl, iv, rp);
            end else begin
                roll = $urandom_range(99);
                if (roll < 88) begin
                    cur_now = cur_now + $urandom_range(0, 8);
                    pop_due(cur_now);
                end else if (roll < 94) begin
                    pop_due($urandom);
                end else begin
                    pop_due('1);
                end
            end
        end
        steady = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then a short quiet period
        while (board.pending_outcomes.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        board.failures += board.pending_outcomes.size();

        $display("%0d results checked: %0d pushes (%0d refused when full), %0d pops due",
                 board.checked, board.n_push, board.n_refused, board.n_pop_hit);
        $display("%0d pops found nothing due, %0d repeats re-queued, peak fill %0d",
                 board.n_pop_miss, board.n_requeued, board.peak_fill);
        if (board.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
